FILE: rtl/core/gf2m_affine_hash_matcher_unit_defines.svh
// Assertion macros shared by the hash matcher RTL.
`ifndef GF2M_AFFINE_HASH_MATCHER_UNIT_DEFINES_SVH
`define GF2M_AFFINE_HASH_MATCHER_UNIT_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define GFAHM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GFAHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gfahm_pkg.sv
// Types, constants and helper functions of the GF(2^m) affine hash matcher.
package gfahm_pkg;

  localparam int unsigned MaxDegree = 32;
  localparam int unsigned ElemW     = 32;
  localparam int unsigned DataW     = 32;
  localparam int unsigned DegW      = 6;
  localparam int unsigned CfgAddrW  = 5;
  localparam int unsigned NumCells  = ElemW;
  localparam int unsigned EffMax    = (MaxDegree < ElemW) ? MaxDegree : ElemW;
  localparam int unsigned MinDegree = 2;

  typedef enum logic [2:0] {
    RegFieldDegree = 3'd0,
    RegHashBits    = 3'd1,
    RegModulusLow  = 3'd2,
    RegMultKey     = 3'd3,
    RegAddKey      = 3'd4,
    RegTargetHash  = 3'd5
  } reg_idx_e;

  localparam logic [DegW-1:0]  FieldDegreeRst = DegW'(26);
  localparam logic [DegW-1:0]  HashBitsRst    = DegW'(18);
  localparam logic [DataW-1:0] ModulusLowRst  = '0;
  localparam logic [DataW-1:0] MultKeyRst     = DataW'(1);
  localparam logic [DataW-1:0] AddKeyRst      = '0;
  localparam logic [DataW-1:0] TargetHashRst  = '0;

  // Configuration register contents.
  typedef struct packed {
    logic [DegW-1:0]  field_degree;
    logic [DegW-1:0]  hash_bits;
    logic [DataW-1:0] modulus_low;
    logic [DataW-1:0] mult_key;
    logic [DataW-1:0] add_key;
    logic [DataW-1:0] target_hash;
  } cfg_t;

  // Field constants derived from the configuration, shared by every cell.
  typedef struct packed {
    logic [ElemW-1:0] mmask;
    logic [ElemW-1:0] top_bit;
    logic [ElemW-1:0] fmod;
    logic [ElemW-1:0] mult;
  } key_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic [ElemW-1:0] prod;
    logic [ElemW-1:0] elem;
    logic             last;
  } stage_t;

  // Mask of the low n bits, all ones from the full word width upward.
  function automatic logic [ElemW-1:0] low_mask(input logic [DegW-1:0] n);
    logic [ElemW-1:0] res;
    if (n >= DegW'(ElemW)) begin
      res = '1;
    end else begin
      res = (ElemW'(1) << n) - ElemW'(1);
    end
    return res;
  endfunction

  // Degree clamped to the supported range.
  function automatic logic [DegW-1:0] eff_degree(input logic [DegW-1:0] m);
    logic [DegW-1:0] res;
    res = m;
    if (res > DegW'(EffMax)) begin
      res = DegW'(EffMax);
    end
    if (res < DegW'(MinDegree)) begin
      res = DegW'(MinDegree);
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/gfahm_regs.sv
// APB-style configuration register file of the hash matcher.
module gfahm_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gfahm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [gfahm_pkg::DataW-1:0]     pwdata,
  output logic [gfahm_pkg::DataW-1:0]     prdata,
  output logic                            pready,
  output gfahm_pkg::cfg_t                 cfg_o
);

  gfahm_pkg::cfg_t      cfg_q, cfg_d;
  gfahm_pkg::reg_idx_e  idx;
  logic                 wr_en;

  assign idx    = gfahm_pkg::reg_idx_e'(paddr[gfahm_pkg::CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        gfahm_pkg::RegFieldDegree: cfg_d.field_degree = pwdata[gfahm_pkg::DegW-1:0];
        gfahm_pkg::RegHashBits:    cfg_d.hash_bits    = pwdata[gfahm_pkg::DegW-1:0];
        gfahm_pkg::RegModulusLow:  cfg_d.modulus_low  = pwdata;
        gfahm_pkg::RegMultKey:     cfg_d.mult_key     = pwdata;
        gfahm_pkg::RegAddKey:      cfg_d.add_key      = pwdata;
        gfahm_pkg::RegTargetHash:  cfg_d.target_hash  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gfahm_pkg::RegFieldDegree: prdata = gfahm_pkg::DataW'(cfg_q.field_degree);
      gfahm_pkg::RegHashBits:    prdata = gfahm_pkg::DataW'(cfg_q.hash_bits);
      gfahm_pkg::RegModulusLow:  prdata = cfg_q.modulus_low;
      gfahm_pkg::RegMultKey:     prdata = cfg_q.mult_key;
      gfahm_pkg::RegAddKey:      prdata = cfg_q.add_key;
      gfahm_pkg::RegTargetHash:  prdata = cfg_q.target_hash;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.field_degree <= gfahm_pkg::FieldDegreeRst;
      cfg_q.hash_bits    <= gfahm_pkg::HashBitsRst;
      cfg_q.modulus_low  <= gfahm_pkg::ModulusLowRst;
      cfg_q.mult_key     <= gfahm_pkg::MultKeyRst;
      cfg_q.add_key      <= gfahm_pkg::AddKeyRst;
      cfg_q.target_hash  <= gfahm_pkg::TargetHashRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/gfahm_cell.sv
// One multiply-reduce cell: folds one element bit into the running product.
module gfahm_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  gfahm_pkg::stage_t stage_i,
  input  gfahm_pkg::key_t   key_i,
  output logic              valid_o,
  output gfahm_pkg::stage_t stage_o
);

  logic              valid_q;
  logic              top_set;
  gfahm_pkg::stage_t stage_q, stage_d;

  // Horner step: p = p*x mod f, then add a when the current element bit is set.
  // The element word rotates left so its next bit is always at the top.
  always_comb begin
    top_set       = |(stage_i.prod & key_i.top_bit);
    stage_d.prod  = ((stage_i.prod << 1) & key_i.mmask)
                  ^ (top_set ? key_i.fmod : '0)
                  ^ (stage_i.elem[gfahm_pkg::ElemW-1] ? key_i.mult : '0);
    stage_d.elem  = {stage_i.elem[gfahm_pkg::ElemW-2:0], stage_i.elem[gfahm_pkg::ElemW-1]};
    stage_d.last  = stage_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: rtl/core/gf2m_affine_hash_matcher_unit.sv
// An input transfer passes through the cell row and then the output register.
// Throughput: one element per cycle while the row advances; a row of 32 cells handles one element bit each.
// Backpressure stalls the whole row; a one-entry input skid keeps ready registered.
// Reset: rst_ni is asynchronous, active low; it empties the row and output and
// loads the register reset values (degree 26, hash bits 18, multiplier 1).
`include "gf2m_affine_hash_matcher_unit_defines.svh"

module gf2m_affine_hash_matcher_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gfahm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [gfahm_pkg::DataW-1:0]     pwdata,
  output logic [gfahm_pkg::DataW-1:0]     prdata,
  output logic                            pready,
  // Element input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gfahm_pkg::ElemW-1:0]     element_i,
  input  logic                            last_element_i,
  // Result output channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gfahm_pkg::ElemW-1:0]     element_out_o,
  output logic [gfahm_pkg::DataW-1:0]     hash_word_o,
  output logic                            is_match_o,
  output logic                            last_out_o
);

  localparam int unsigned NumCells = gfahm_pkg::NumCells;
  localparam int unsigned ElemW    = gfahm_pkg::ElemW;

  gfahm_pkg::cfg_t cfg;
  gfahm_pkg::key_t key;

  // Register file. The user must change the configuration only while the row is
  // empty, which the block does not enforce; the field constants below feed every cell directly.
  gfahm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [gfahm_pkg::DegW-1:0] eff_m;
  logic [ElemW-1:0]           kmask;
  logic [ElemW-1:0]           add_masked;

  // The degree is clamped to 2..32. The reduction test looks at bit m-1 of
  // the product before the shift, which is the coefficient that moves to x^m.
  always_comb begin
    eff_m       = gfahm_pkg::eff_degree(cfg.field_degree);
    key.mmask   = gfahm_pkg::low_mask(eff_m);
    key.top_bit = ElemW'(1) << (eff_m - gfahm_pkg::DegW'(1));
    key.fmod    = cfg.modulus_low & key.mmask;
    key.mult    = cfg.mult_key & key.mmask;
    add_masked  = cfg.add_key & key.mmask;
    // Bits of the hash at or above m are always zero, so clamping k to m is
    // the same as masking with the raw hash width.
    kmask       = gfahm_pkg::low_mask(cfg.hash_bits);
  end

  // Global advance: the whole row moves whenever the output register can take
  // a result. A stalled row parks one incoming transfer in the skid entry.
  logic             adv;
  logic             skid_full_q, skid_full_d;
  logic [ElemW-1:0] skid_elem_q;
  logic             skid_last_q;
  logic             in_xfer;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = !skid_full_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    skid_full_d = skid_full_q;
    if (adv) begin
      skid_full_d = 1'b0;
    end else if (in_xfer) begin
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && in_xfer) begin
      skid_elem_q <= element_i;
      skid_last_q <= last_element_i;
    end
  end

  // Cell row. Cell i folds in element bit 31-i, most significant first. Bits
  // above m are zero after masking and leave the product at zero, so a fixed
  // row of 32 cells serves every degree. After 32 rotations the element word
  // is back in its original order and is echoed as is.
  logic [NumCells:0]  vld;
  gfahm_pkg::stage_t  stg [NumCells+1];

  // The first cell starts from a zero product; the parked transfer goes first.
  assign vld[0] = skid_full_q || in_valid_i;
  assign stg[0] = {ElemW'(0),
                   (skid_full_q ? skid_elem_q : element_i) & key.mmask,
                   (skid_full_q ? skid_last_q : last_element_i)};

  for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
    gfahm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vld[gi]),
      .stage_i (stg[gi]),
      .key_i   (key),
      .valid_o (vld[gi+1]),
      .stage_o (stg[gi+1])
    );
  end

  // Output register: add b, keep the low k bits, and compare with the full
  // 32-bit target so that a target wider than k never matches.
  logic                         out_valid_q;
  logic [ElemW-1:0]             hash_d;

  assign hash_d = (stg[NumCells].prod ^ add_masked) & kmask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      element_out_o <= stg[NumCells].elem;
      hash_word_o   <= gfahm_pkg::DataW'(hash_d);
      is_match_o    <= (gfahm_pkg::DataW'(hash_d) == cfg.target_hash);
      last_out_o    <= stg[NumCells].last;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result never carries hash bits above the configured width.
  `GFAHM_ASSERT(a_hash_width, !out_valid_o || ((hash_word_o & ~kmask) == '0), "hash bits above k set")
  // A stalled output freezes the cell row.
  `GFAHM_ASSERT_NEXT(a_row_frozen, out_valid_o && !out_ready_i, $stable(vld[NumCells:1]), "cell row moved while output stalled")
  // A parked input transfer is released as soon as the row advances.
  `GFAHM_ASSERT_NEXT(a_skid_drain, skid_full_q && adv, !skid_full_q, "skid entry not drained on advance")
  // The skid entry only fills while the row is stalled.
  `GFAHM_ASSERT_NEXT(a_skid_fill, !skid_full_q && adv, !skid_full_q, "skid entry filled while row advanced")

endmodule

FILE: tb/hash_match_checker.sv
// Watches the channels and register port of the hash matcher and checks each result.
`timescale 1ns / 100ps

module hash_match_checker
  import gfahm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  input  logic                pready,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  logic [ElemW-1:0]    element_i,
  input  logic                last_element_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [ElemW-1:0]    element_out_o,
  input  logic [DataW-1:0]    hash_word_o,
  input  logic                is_match_o,
  input  logic                last_out_o,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  result_count_o,
  output int                  match_count_o
);

  typedef struct packed {
    logic [31:0] element;
    logic [31:0] hash;
    logic        match;
    logic        last;
  } hash_result_t;

  // Shadow copy of the registers, updated from observed writes.
  logic [DegW-1:0]  degree_q;
  logic [DegW-1:0]  kept_bits_q;
  logic [DataW-1:0] modulus_q;
  logic [DataW-1:0] mult_q;
  logic [DataW-1:0] add_q;
  logic [DataW-1:0] target_q;

  hash_result_t pending_hashes[$];

  // Shift-and-add multiply of a by x, reducing by f after every shift.
  function automatic hash_result_t predict_hash(input logic [31:0] elem, input logic last);
    int unsigned  m;
    int unsigned  k;
    logic [63:0]  mmask;
    logic [63:0]  fpoly;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  x;
    logic [63:0]  acc;
    logic [63:0]  h;
    hash_result_t r;
    m = degree_q;
    if (m > 32) m = 32;
    if (m < 2) m = 2;
    k = kept_bits_q;
    if (k > m) k = m;
    mmask = (64'd1 << m) - 64'd1;
    fpoly = ({32'd0, modulus_q} & mmask) | (64'd1 << m);
    a = {32'd0, mult_q} & mmask;
    b = {32'd0, add_q} & mmask;
    x = {32'd0, elem} & mmask;
    acc = '0;
    for (int i = int'(m) - 1; i >= 0; i--) begin
      acc = acc << 1;
      if (acc[m]) acc = acc ^ fpoly;
      if (x[i]) acc = acc ^ a;
    end
    h = (acc ^ b) & ((64'd1 << k) - 64'd1);
    r.element = x[31:0];
    r.hash    = h[31:0];
    r.match   = (h == {32'd0, target_q});
    r.last    = last;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    fail_count_o++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q    <= FieldDegreeRst;
      kept_bits_q <= HashBitsRst;
      modulus_q   <= ModulusLowRst;
      mult_q      <= MultKeyRst;
      add_q       <= AddKeyRst;
      target_q    <= TargetHashRst;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[CfgAddrW-1:2]))
        RegFieldDegree: degree_q    <= pwdata[DegW-1:0];
        RegHashBits:    kept_bits_q <= pwdata[DegW-1:0];
        RegModulusLow:  modulus_q   <= pwdata;
        RegMultKey:     mult_q      <= pwdata;
        RegAddKey:      add_q       <= pwdata;
        RegTargetHash:  target_q    <= pwdata;
        default: ;
      endcase
    end
  end

  initial begin
    fail_count_o   = 0;
    pending_o      = 0;
    result_count_o = 0;
    match_count_o  = 0;
  end

  always @(posedge clk_i) begin
    hash_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        result_count_o++;
        if (is_match_o) match_count_o++;
        if (pending_hashes.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with nothing expected, actual element %h hash %h",
                   $time, element_out_o, hash_word_o);
        end else begin
          want = pending_hashes.pop_front();
          if (element_out_o !== want.element)
            report_field("element_out", want.element, element_out_o);
          if (hash_word_o !== want.hash)
            report_field("hash_word", want.hash, hash_word_o);
          if (is_match_o !== want.match)
            report_field("is_match", 32'(want.match), 32'(is_match_o));
          if (last_out_o !== want.last)
            report_field("last_out", 32'(want.last), 32'(last_out_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_hashes = {pending_hashes, predict_hash(element_i, last_element_i)};
      end
      pending_o <= pending_hashes.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the hash matcher testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
  import gfahm_pkg::*;

  // A result passes the cell row and then the output register; the tail lets the last ones leave.
  localparam int TailCycles    = 48;
  // No transfer on any port for this many cycles means the block has hung.
  localparam int WatchdogLimit = 4000;
  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ElemW-1:0]    element = '0;
  logic                last_element = 1'b0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ElemW-1:0]    element_out;
  logic [DataW-1:0]    hash_word;
  logic                is_match;
  logic                last_out;

  int                  fail_count;
  int                  pending;
  int                  result_count;
  int                  match_count;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  gf2m_affine_hash_matcher_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .element_i      (element),
    .last_element_i (last_element),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .element_out_o  (element_out),
    .hash_word_o    (hash_word),
    .is_match_o     (is_match),
    .last_out_o     (last_out)
  );

  hash_match_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .element_i      (element),
    .last_element_i (last_element),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .element_out_o  (element_out),
    .hash_word_o    (hash_word),
    .is_match_o     (is_match),
    .last_out_o     (last_out),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .match_count_o  (match_count)
  );

  // The receiver decides afresh every cycle whether it can take a result.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The watchdog restarts whenever anything moves on either channel or the register port.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A register write is a setup phase followed by an access phase; the write lands at the
  // edge that ends the access phase.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_hash_setup(input logic [31:0] degree, input logic [31:0] kept_bits,
                                 input logic [31:0] modulus, input logic [31:0] mult,
                                 input logic [31:0] addend, input logic [31:0] target);
    write_reg(RegFieldDegree, degree);
    write_reg(RegHashBits, kept_bits);
    write_reg(RegModulusLow, modulus);
    write_reg(RegMultKey, mult);
    write_reg(RegAddKey, addend);
    write_reg(RegTargetHash, target);
  endtask

  // The sender may idle before offering the element. Valid stays high from one element to
  // the next when there is no idle gap, so it is never lowered and raised in one step.
  task automatic push_element(input logic [31:0] elem, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    element      <= elem;
    last_element <= last;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Every element yields one result, so the block is idle once nothing is outstanding.
  // The extra edge lets the checker's count catch up with the last input transfer.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Idling modes: none, a slow sender, a slow receiver, and both sides a little slow.
  task automatic set_idling(input int unsigned mode);
    case (mode)
      1: begin
        send_idle_pct  = 61;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 61;
      end
      3: begin
        send_idle_pct  = 30;
        recv_stall_pct = 30;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Elements lean toward the edges: zero, all ones, single bits and small values.
  function automatic logic [31:0] pick_element();
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      2:       v = 32'd1 << $urandom_range(31);
      3:       v = $urandom_range(255);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [31:0] low_bits(input int unsigned n);
    return 32'((64'd1 << n) - 64'd1);
  endfunction

  initial begin
    int unsigned degree;
    int unsigned kept_bits;
    logic [31:0] addend;
    set_idling(0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed elements under the reset setup: degree 26, 18 hash bits, multiplier 1 and
    // modulus x^26, so the hash is the element's low 18 bits and a zero target matches
    // whenever those bits are clear. Bits at and above the degree must be dropped.
    push_element(32'h0000_0000, 1'b0);
    push_element(32'hFFFF_FFFF, 1'b1);
    push_element(32'h0000_0001, 1'b0);
    push_element(32'h8000_0000, 1'b1);
    push_element(32'h0004_0000, 1'b0);
    push_element(32'h0200_0000, 1'b0);
    push_element(32'h0400_0000, 1'b1);
    push_element(32'h03FF_FFFF, 1'b0);
    push_element(32'hAAAA_AAAA, 1'b0);
    push_element(32'h5555_5555, 1'b1);
    push_element(32'hFC00_0000, 1'b0);
    push_element(32'h0003_FFFF, 1'b1);
    wait_drained();

    // Full width field with every modulus and multiplier bit set and an all-ones target.
    load_hash_setup(32, 32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom(), 32'hFFFF_FFFF);
    push_element(32'hFFFF_FFFF, 1'b1);
    push_element(32'h8000_0001, 1'b0);
    push_element(32'h0000_0002, 1'b1);
    wait_drained();

    // A degree below the minimum clamps to two; extra hash bits saturate to the degree.
    load_hash_setup(32'hFFFF_FFC0, 63, 32'h0000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0);
    push_element(32'h0000_0003, 1'b0);
    push_element(32'hFFFF_FFFD, 1'b1);
    push_element(32'h0000_0002, 1'b0);
    wait_drained();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: load_hash_setup(32, 32, $urandom(), $urandom(), $urandom(), $urandom());
        // Zero hash bits: every hash is zero and so matches a zero target.
        1: load_hash_setup(1, 0, 0, $urandom(), $urandom(), 0);
        // Degree above the maximum clamps to 32; a four bit hash matches often.
        2: load_hash_setup(63, 4, $urandom(), $urandom(), $urandom(), $urandom_range(15));
        3: begin
          // Multiplier bits only above the degree, so the product is zero and every
          // hash equals the kept bits of the addend, which is also the target.
          degree    = $urandom_range(2, 32);
          kept_bits = $urandom_range(1, degree);
          addend    = $urandom();
          load_hash_setup(degree, kept_bits, $urandom(), $urandom() << degree,
                          addend, addend & low_bits(kept_bits));
        end
        4: begin
          // A target bit at or above the kept width means no element can match.
          degree    = $urandom_range(2, 31);
          kept_bits = $urandom_range(1, degree);
          load_hash_setup(degree, kept_bits, $urandom(), $urandom(), $urandom(),
                          $urandom() | (32'd1 << kept_bits));
        end
        5: load_hash_setup(2, 2, 32'h3, 32'h2, 32'h1, $urandom_range(3));
        6: load_hash_setup(8, 8, 32'h1B, $urandom(), $urandom(), $urandom_range(255));
        default: begin
          degree    = $urandom_range(0, 63);
          kept_bits = $urandom_range(0, 63);
          load_hash_setup(degree, kept_bits, $urandom(), $urandom(), $urandom(),
                          $urandom_range(3));
        end
      endcase
      set_idling(phase % 4);
      repeat (ItemsPerPhase) push_element(pick_element(), $urandom_range(7) == 0);
      wait_drained();
    end

    set_idling(0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Hashed %0d elements under %0d register setups plus the reset setup.",
             result_count, NumPhases + 2);
    $display("%0d results matched the target; %0d checks failed.", match_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
